// ----- rtl/sps_pkg.sv -----
// Shared types, constants and helper functions for the slotted page store.
// Used by the channel interfaces and by every module of the block but sps_ram.
`timescale 1ns / 1ps

package sps_pkg;

  // Page geometry.
  localparam int PAGE_BYTES    = 4096;
  localparam int HEADER_BYTES  = 8;
  localparam int SLOT_BYTES    = 4;
  localparam int MAX_TUPLE_LEN = 64;
  localparam int SLOT_LIMIT    = 1024;

  // Field and pointer widths.
  localparam int FP_W    = $clog2(PAGE_BYTES + 1);
  localparam int BADDR_W = $clog2(PAGE_BYTES);
  localparam int SID_W   = 10;
  localparam int SCNT_W  = 11;
  localparam int LEN_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int FS_W    = 13;

  // Command queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_GET    = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIR,
    BK_STREAM
  } bk_state_t;

  // One classified request as it travels through the queue.
  typedef struct packed {
    cmd_t               cmd;
    logic               first;
    logic               last;
    logic [SID_W-1:0]   slot_id;
    logic [BYTE_W-1:0]  data_byte;
    logic [LEN_W-1:0]   tuple_len;
  } op_t;

  // One slot directory entry. The fill count is the number of tuple bytes
  // that actually arrived; bytes past it read as zero.
  typedef struct packed {
    logic [FP_W-1:0]  off;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] fill;
  } slot_ent_t;

  localparam int ENT_W = $bits(slot_ent_t);

  // Free bytes between the directory and the free pointer, floored at zero.
  function automatic logic [FS_W-1:0] free_space_of(input logic [FP_W-1:0] fp,
                                                    input logic [SCNT_W-1:0] st);
    logic [FP_W:0] used;
    logic [FP_W:0] fp_x;
    used = (FP_W + 1)'(HEADER_BYTES) + (FP_W + 1)'(st) * (FP_W + 1)'(SLOT_BYTES);
    fp_x = {1'b0, fp};
    if (fp_x >= used) begin
      free_space_of = FS_W'(fp_x - used);
    end else begin
      free_space_of = '0;
    end
  endfunction

endpackage

// ----- rtl/sps_in_if.sv -----
// Request channel of the slotted page store: valid/ready plus one request.
// Depends on sps_pkg for the command type and field widths.
`timescale 1ns / 1ps

interface sps_in_if;
  import sps_pkg::*;

  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [SID_W-1:0]  slot_id;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  tuple_len;
  logic              last;

  modport source (output valid, command, slot_id, data_byte, tuple_len, last,
                  input ready);
  modport sink   (input valid, command, slot_id, data_byte, tuple_len, last,
                  output ready);
endinterface

// ----- rtl/sps_out_if.sv -----
// Result channel of the slotted page store: valid/ready plus one result.
// Depends on sps_pkg for the status type and field widths.
`timescale 1ns / 1ps

interface sps_out_if;
  import sps_pkg::*;

  logic              valid;
  logic              ready;
  status_t           status;
  logic [SID_W-1:0]  slot_number;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic [FS_W-1:0]   free_space;
  logic              end_of_run;

  modport source (output valid, status, slot_number, out_byte, byte_valid,
                  free_space, end_of_run, input ready);
  modport sink   (input valid, status, slot_number, out_byte, byte_valid,
                  free_space, end_of_run, output ready);
endinterface

// ----- rtl/sps_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enable-held read. No dependencies.
`timescale 1ns / 1ps

module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data register holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/sps_front.sv -----
// Front end: accepts requests and marks the first byte of each insert run.
// Depends on sps_pkg and sps_in_if; feeds the command queue.
`timescale 1ns / 1ps

module sps_front (
  input  logic         clk,
  input  logic         rst_n,
  sps_in_if.sink       in_ch,
  input  logic         q_full,
  output logic         push_valid,
  output sps_pkg::op_t push_op
);
  import sps_pkg::*;

  logic in_run_r;
  logic in_run_nxt;
  logic accept;

  // A request is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Classify the request: an insert byte opens a run unless one is open.
  always_comb begin
    push_valid        = accept;
    push_op.cmd       = in_ch.command;
    push_op.first     = (in_ch.command == CMD_INSERT) && !in_run_r;
    push_op.last      = in_ch.last;
    push_op.slot_id   = in_ch.slot_id;
    push_op.data_byte = in_ch.data_byte;
    push_op.tuple_len = in_ch.tuple_len;
  end

  // A run stays open until its last byte or any other command.
  always_comb begin
    in_run_nxt = in_run_r;
    if (accept) begin
      in_run_nxt = (in_ch.command == CMD_INSERT) && !in_ch.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r <= 1'b0;
    end else begin
      in_run_r <= in_run_nxt;
    end
  end

endmodule

// ----- rtl/sps_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on sps_pkg for the request struct and queue depth.
`timescale 1ns / 1ps

module sps_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  input  sps_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output sps_pkg::op_t head_op
);
  import sps_pkg::*;

  op_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push_en;
  logic              pop_en;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = mem_r[rd_ptr_r];
  assign push_en    = push_valid && !full;
  assign pop_en     = pop && head_valid;

  // Pointer and occupancy update; pointers wrap on their own.
  always_comb begin
    wr_ptr_nxt = push_en ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_en ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_en && !pop_en) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push_en && pop_en) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage for queued requests.
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- rtl/sps_back.sv -----
// Back end: executes queued requests against the page and slot directory.
// Depends on sps_pkg, sps_out_if and two sps_ram instances.
`timescale 1ns / 1ps

module sps_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         head_valid,
  input  sps_pkg::op_t head_op,
  output logic         pop,
  sps_out_if.source    out_ch
);
  import sps_pkg::*;

  // Sequencer and page state.
  bk_state_t         state_r, state_nxt;
  logic [FP_W-1:0]   fp_r, fp_nxt;
  logic [SCNT_W-1:0] st_r, st_nxt;

  // Open insert run.
  logic              ins_acc_r, ins_acc_nxt;
  logic [FP_W-1:0]   run_base_r, run_base_nxt;
  logic [LEN_W-1:0]  run_len_r, run_len_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt;

  // Get in progress.
  logic [SID_W-1:0]  get_sid_r, get_sid_nxt;
  logic              get_oor_r, get_oor_nxt;
  logic [FP_W-1:0]   s_off_r, s_off_nxt;
  logic [LEN_W-1:0]  s_len_r, s_len_nxt;
  logic [LEN_W-1:0]  s_fill_r, s_fill_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;

  // Byte stage that sits on the tuple RAM read register.
  logic              p_valid_r, p_valid_nxt;
  logic              p_zero_r, p_zero_nxt;
  logic              p_end_r, p_end_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [SID_W-1:0]  out_slot_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_bvalid_r;
  logic [FS_W-1:0]   out_fs_r;
  logic              out_end_r;

  // Memory ports.
  logic              slot_wr_en, slot_rd_en;
  logic [SID_W-1:0]  slot_wr_addr, slot_rd_addr;
  slot_ent_t         slot_wr_ent, slot_rd;
  logic [ENT_W-1:0]  slot_rd_raw;
  logic              tup_wr_en, tup_rd_en;
  logic [FP_W-1:0]   tup_wr_sum, tup_rd_sum;
  logic [BYTE_W-1:0] tup_rd_data;

  // Shared decisions.
  logic              out_free, move_p, can_emit, need_emit, issue, stream_last;
  logic [FS_W-1:0]   fs_cur, fs_nxt;
  logic              ins_fit, acc_cur, ins_wr, oor_hd;
  logic [FP_W-1:0]   base_cur;
  logic [LEN_W-1:0]  len_cur, fill_cur, fill_new;
  logic              dir_empty, dir_single;

  // Single result from the sequencer.
  logic              em_valid;
  status_t           em_status;
  logic [SID_W-1:0]  em_slot;

  sps_ram #(.WIDTH(ENT_W), .DEPTH(SLOT_LIMIT)) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_ent),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_raw)
  );

  sps_ram #(.WIDTH(BYTE_W), .DEPTH(PAGE_BYTES)) u_tuple_ram (
    .clk     (clk),
    .wr_en   (tup_wr_en),
    .wr_addr (tup_wr_sum[BADDR_W-1:0]),
    .wr_data (head_op.data_byte),
    .rd_en   (tup_rd_en),
    .rd_addr (tup_rd_sum[BADDR_W-1:0]),
    .rd_data (tup_rd_data)
  );

  assign slot_rd = slot_ent_t'(slot_rd_raw);

  // Handshake with the output register and the byte stage.
  assign out_free  = !out_valid_r || out_ch.ready;
  assign move_p    = p_valid_r && out_free;
  assign can_emit  = out_free && !p_valid_r;
  assign need_emit = (head_op.cmd == CMD_INIT) || (head_op.cmd == CMD_DELETE) ||
                     ((head_op.cmd == CMD_INSERT) && head_op.last);
  assign pop       = (state_r == BK_IDLE) && head_valid && !p_valid_r &&
                     (!need_emit || can_emit);

  // Insert run bookkeeping; the first byte decides whether the tuple fits.
  assign fs_cur   = free_space_of(fp_r, st_r);
  assign ins_fit  = (head_op.tuple_len <= LEN_W'(MAX_TUPLE_LEN)) &&
                    (st_r < SCNT_W'(SLOT_LIMIT)) &&
                    (fs_cur >= FS_W'(head_op.tuple_len) + FS_W'(SLOT_BYTES));
  assign base_cur = head_op.first ? fp_r - FP_W'(head_op.tuple_len) : run_base_r;
  assign len_cur  = head_op.first ? head_op.tuple_len : run_len_r;
  assign acc_cur  = head_op.first ? ins_fit : ins_acc_r;
  assign fill_cur = head_op.first ? '0 : fill_r;
  assign ins_wr   = acc_cur && (fill_cur < len_cur);
  assign fill_new = fill_cur + LEN_W'(ins_wr);
  assign oor_hd   = (SCNT_W'(head_op.slot_id) >= st_r);

  // Directory lookup outcome and stream progress.
  assign dir_empty   = get_oor_r || ((slot_rd.off == '0) && (slot_rd.len == '0));
  assign dir_single  = dir_empty || (slot_rd.len == '0);
  assign issue       = (state_r == BK_STREAM) && (!p_valid_r || move_p);
  assign stream_last = (idx_r == s_len_r - LEN_W'(1));

  assign tup_wr_sum = base_cur + FP_W'(fill_cur);
  assign tup_rd_sum = s_off_r + FP_W'(idx_r);
  assign tup_rd_en  = issue;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (pop && (head_op.cmd == CMD_GET)) begin
          state_nxt = BK_DIR;
        end
      end
      BK_DIR: begin
        if (!dir_single) begin
          state_nxt = BK_STREAM;
        end else if (can_emit) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_STREAM: begin
        if (issue && stream_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs: page state, memory ports and single results.
  always_comb begin
    fp_nxt       = fp_r;
    st_nxt       = st_r;
    ins_acc_nxt  = ins_acc_r;
    run_base_nxt = run_base_r;
    run_len_nxt  = run_len_r;
    fill_nxt     = fill_r;
    get_sid_nxt  = get_sid_r;
    get_oor_nxt  = get_oor_r;
    s_off_nxt    = s_off_r;
    s_len_nxt    = s_len_r;
    s_fill_nxt   = s_fill_r;
    idx_nxt      = idx_r;
    em_valid     = 1'b0;
    em_status    = ST_OK;
    em_slot      = '0;
    slot_wr_en   = 1'b0;
    slot_wr_addr = head_op.slot_id;
    slot_wr_ent  = '0;
    slot_rd_en   = 1'b0;
    slot_rd_addr = head_op.slot_id;
    tup_wr_en    = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (pop) begin
          unique case (head_op.cmd)
            CMD_INIT: begin
              fp_nxt   = FP_W'(PAGE_BYTES);
              st_nxt   = '0;
              em_valid = 1'b1;
            end
            CMD_INSERT: begin
              ins_acc_nxt  = acc_cur;
              run_base_nxt = base_cur;
              run_len_nxt  = len_cur;
              fill_nxt     = fill_new;
              tup_wr_en    = ins_wr;
              if (head_op.last) begin
                em_valid = 1'b1;
                if (acc_cur) begin
                  em_slot          = st_r[SID_W-1:0];
                  fp_nxt           = base_cur;
                  st_nxt           = st_r + SCNT_W'(1);
                  slot_wr_en       = 1'b1;
                  slot_wr_addr     = st_r[SID_W-1:0];
                  slot_wr_ent.off  = base_cur;
                  slot_wr_ent.len  = len_cur;
                  slot_wr_ent.fill = fill_new;
                end else begin
                  em_status = ST_NO_SPACE;
                end
              end
            end
            CMD_GET: begin
              slot_rd_en  = 1'b1;
              get_sid_nxt = head_op.slot_id;
              get_oor_nxt = oor_hd;
            end
            CMD_DELETE: begin
              em_valid = 1'b1;
              em_slot  = head_op.slot_id;
              if (oor_hd) begin
                em_status = ST_EMPTY;
              end else begin
                slot_wr_en = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      BK_DIR: begin
        s_off_nxt  = slot_rd.off;
        s_len_nxt  = slot_rd.len;
        s_fill_nxt = slot_rd.fill;
        idx_nxt    = '0;
        if (dir_single && can_emit) begin
          em_valid  = 1'b1;
          em_slot   = get_sid_r;
          em_status = dir_empty ? ST_EMPTY : ST_OK;
        end
      end
      BK_STREAM: begin
        if (issue) begin
          idx_nxt = idx_r + LEN_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Byte stage and output register control.
  always_comb begin
    p_valid_nxt = p_valid_r;
    p_zero_nxt  = p_zero_r;
    p_end_nxt   = p_end_r;
    if (issue) begin
      p_valid_nxt = 1'b1;
      p_zero_nxt  = (idx_r >= s_fill_r);
      p_end_nxt   = stream_last;
    end else if (move_p) begin
      p_valid_nxt = 1'b0;
    end
    if (move_p || em_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign fs_nxt = free_space_of(fp_nxt, st_nxt);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      fp_r        <= FP_W'(PAGE_BYTES);
      st_r        <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      st_r        <= st_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ins_acc_r  <= ins_acc_nxt;
    run_base_r <= run_base_nxt;
    run_len_r  <= run_len_nxt;
    fill_r     <= fill_nxt;
    get_sid_r  <= get_sid_nxt;
    get_oor_r  <= get_oor_nxt;
    s_off_r    <= s_off_nxt;
    s_len_r    <= s_len_nxt;
    s_fill_r   <= s_fill_nxt;
    idx_r      <= idx_nxt;
    p_zero_r   <= p_zero_nxt;
    p_end_r    <= p_end_nxt;
    if (move_p) begin
      out_status_r <= ST_OK;
      out_slot_r   <= get_sid_r;
      out_byte_r   <= p_zero_r ? '0 : tup_rd_data;
      out_bvalid_r <= 1'b1;
      out_fs_r     <= fs_nxt;
      out_end_r    <= p_end_r;
    end else if (em_valid) begin
      out_status_r <= em_status;
      out_slot_r   <= em_slot;
      out_byte_r   <= '0;
      out_bvalid_r <= 1'b0;
      out_fs_r     <= fs_nxt;
      out_end_r    <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot_number = out_slot_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.byte_valid  = out_bvalid_r;
  assign out_ch.free_space  = out_fs_r;
  assign out_ch.end_of_run  = out_end_r;

endmodule

// ----- rtl/slotted_page_store_unit.sv -----
// Top level of the slotted page store: front end, command queue, back end.
// Depends on sps_pkg, sps_in_if, sps_out_if, sps_front, sps_queue, sps_back.
`timescale 1ns / 1ps

// Usage:
// Requests enter on in_ch (valid/ready) and results leave on out_ch. Each
// request carries a command: init, insert byte, get or delete. An insert is a
// run of byte requests; only the last byte gives a result (slot id or
// no-space status). A get gives one result per byte of the tuple length, or
// one for a zero-length, empty, deleted or out-of-range slot. Init and delete
// give one each. The front end takes a request every cycle while the
// four-entry command queue has room. The back end executes one insert byte,
// init or delete per cycle while the output register is free; each result
// is registered in the cycle after execution. A get reads the slot directory,
// then streams one byte per cycle from the tuple RAM while the receiver takes
// them, set by its single read port; the next request waits until the byte
// stage is empty. After reset the page is empty (free pointer at the page
// size, no slots) and the queue is empty; no clearing pass is needed. When
// the receiver stalls, the output register and byte stage hold, the back end
// stops at the next result, and the queue fills until in_ch.ready drops.
module slotted_page_store_unit (
  input  logic      clk,
  input  logic      rst_n,
  sps_in_if.sink    in_ch,
  sps_out_if.source out_ch
);
  import sps_pkg::*;

  logic q_full;
  logic push_valid;
  op_t  push_op;
  logic head_valid;
  op_t  head_op;
  logic pop;

  sps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_op    (push_op)
  );

  sps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  sps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ----- tb/page_store_checker.sv -----
// Watches both channels of the slotted page store, predicts every result from
// the accepted requests and compares it with what the block returns.
// Depends on sps_pkg, sps_in_if and sps_out_if.
`timescale 1ns / 1ps

module page_store_checker (
  input  logic clk,
  input  logic rst_n,
  sps_in_if    in_mon,
  sps_out_if   out_mon,
  output int   mismatch_total,
  output int   results_owed
);
  import sps_pkg::*;

  // Progress of an insert run: none open, bytes being stored, or dropped.
  typedef enum logic [1:0] {
    RUN_IDLE,
    RUN_TAKE,
    RUN_DROP
  } run_mode_t;

  typedef struct packed {
    status_t           status;
    logic [SID_W-1:0]  slot;
    logic [BYTE_W-1:0] data;
    logic              data_ok;
    logic [FS_W-1:0]   space;
    logic              run_end;
  } page_result_t;

  page_result_t owed_q[$];
  page_result_t head;

  // Shadow copy of the page.
  logic [BYTE_W-1:0] page_mem [PAGE_BYTES];
  int dir_off [SLOT_LIMIT];
  int dir_len [SLOT_LIMIT];
  int heap_top;
  int slot_count;
  int fill_ptr;
  int run_base;
  int run_len;
  run_mode_t run_mode;

  // Empty page after reset.
  initial begin
    for (int a = 0; a < PAGE_BYTES; a++) page_mem[a] = '0;
    for (int s = 0; s < SLOT_LIMIT; s++) begin
      dir_off[s] = 0;
      dir_len[s] = 0;
    end
    heap_top       = PAGE_BYTES;
    slot_count     = 0;
    fill_ptr       = 0;
    run_base       = 0;
    run_len        = 0;
    run_mode       = RUN_IDLE;
    mismatch_total = 0;
    results_owed   = 0;
  end

  // Bytes between the end of the slot directory and the heap, never negative.
  function automatic int bytes_free();
    int used;
    used = HEADER_BYTES + slot_count * SLOT_BYTES;
    return (heap_top >= used) ? heap_top - used : 0;
  endfunction

  // Queue one expected result; the free space is taken after the update.
  task automatic owe(input status_t st, input int slot, input int data,
                     input bit data_ok, input bit run_end);
    page_result_t r;
    r.status  = st;
    r.slot    = SID_W'(slot);
    r.data    = BYTE_W'(data);
    r.data_ok = data_ok;
    r.space   = FS_W'(bytes_free());
    r.run_end = run_end;
    owed_q.push_back(r);
  endtask

  // Apply one accepted request to the shadow page.
  task automatic apply_request(input cmd_t cmd, input int sid, input int dbyte,
                               input int tlen, input bit lst);
    int off;
    int len;
    int id;
    if (cmd != CMD_INSERT) run_mode = RUN_IDLE;
    case (cmd)
      CMD_INIT: begin
        heap_top   = PAGE_BYTES;
        slot_count = 0;
        owe(ST_OK, 0, 0, 1'b0, 1'b1);
      end
      CMD_INSERT: begin
        // The first byte of a run decides whether the tuple fits.
        if (run_mode == RUN_IDLE) begin
          if (tlen <= MAX_TUPLE_LEN && slot_count < SLOT_LIMIT &&
              bytes_free() >= tlen + SLOT_BYTES) begin
            run_len  = tlen;
            run_base = heap_top - tlen;
            for (int i = 0; i < tlen; i++) begin
              if (run_base + i < PAGE_BYTES) page_mem[run_base + i] = '0;
            end
            fill_ptr = run_base;
            run_mode = RUN_TAKE;
          end else begin
            run_mode = RUN_DROP;
          end
        end
        // Bytes past the tuple length are dropped.
        if (run_mode == RUN_TAKE && fill_ptr < run_base + run_len) begin
          if (fill_ptr < PAGE_BYTES) page_mem[fill_ptr] = BYTE_W'(dbyte);
          fill_ptr++;
        end
        if (lst) begin
          if (run_mode == RUN_TAKE) begin
            id          = slot_count;
            heap_top    = run_base;
            dir_off[id] = run_base;
            dir_len[id] = run_len;
            slot_count++;
            owe(ST_OK, id, 0, 1'b0, 1'b1);
          end else begin
            owe(ST_NO_SPACE, 0, 0, 1'b0, 1'b1);
          end
          run_mode = RUN_IDLE;
        end
      end
      CMD_GET: begin
        if (sid >= slot_count) begin
          owe(ST_EMPTY, sid, 0, 1'b0, 1'b1);
        end else begin
          off = dir_off[sid];
          len = dir_len[sid];
          if (len > MAX_TUPLE_LEN) len = MAX_TUPLE_LEN;
          // A deleted slot has both offset and length at zero.
          if (dir_off[sid] == 0 && dir_len[sid] == 0) begin
            owe(ST_EMPTY, sid, 0, 1'b0, 1'b1);
          end else if (len == 0) begin
            owe(ST_OK, sid, 0, 1'b0, 1'b1);
          end else begin
            for (int i = 0; i < len; i++) begin
              owe(ST_OK, sid, (off + i < PAGE_BYTES) ? int'(page_mem[off + i]) : 0,
                  1'b1, i == len - 1);
            end
          end
        end
      end
      CMD_DELETE: begin
        if (sid >= slot_count) begin
          owe(ST_EMPTY, sid, 0, 1'b0, 1'b1);
        end else begin
          dir_off[sid] = 0;
          dir_len[sid] = 0;
          owe(ST_OK, sid, 0, 1'b0, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_total++;
    end
  endtask

  // Predict on every accepted request and check every accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        apply_request(in_mon.command, int'(in_mon.slot_id), int'(in_mon.data_byte),
                      int'(in_mon.tuple_len), in_mon.last);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0h slot %0h",
                   $time, out_mon.status, out_mon.slot_number);
          mismatch_total++;
        end else begin
          head = owed_q.pop_front();
          compare_field("status", 16'(head.status), 16'(out_mon.status));
          compare_field("slot_number", 16'(head.slot), 16'(out_mon.slot_number));
          compare_field("out_byte", 16'(head.data), 16'(out_mon.out_byte));
          compare_field("byte_valid", 16'(head.data_ok), 16'(out_mon.byte_valid));
          compare_field("free_space", 16'(head.space), 16'(out_mon.free_space));
          compare_field("end_of_run", 16'(head.run_end), 16'(out_mon.end_of_run));
        end
      end
    end
    results_owed = owed_q.size();
  end

endmodule

// ----- tb/tb.sv -----
// Top of the slotted page store regression: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on sps_pkg, both channel
// interfaces, slotted_page_store_unit and page_store_checker.
`timescale 1ns / 1ps

module tb;
  import sps_pkg::*;

  localparam int ITEM_TARGET   = 310;
  localparam int QUIET_TAIL    = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n;

  sps_in_if  in_ch ();
  sps_out_if out_ch ();

  int mismatch_total;
  int results_owed;
  bit idle_on;
  int sent_count;
  int stall_left;

  slotted_page_store_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  page_store_checker page_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_total (mismatch_total),
    .results_owed   (results_owed)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run ends here if the block hangs.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("slotted_page_store_unit regression: fail");
    $finish;
  end

  // Receiver stalls in short random bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Present one request and hold it until the block takes it.
  task automatic send_req(input cmd_t cmd, input int sid, input int dbyte,
                          input int tlen, input bit lst);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.slot_id   <= SID_W'(sid);
    in_ch.data_byte <= BYTE_W'(dbyte);
    in_ch.tuple_len <= LEN_W'(tlen);
    in_ch.last      <= lst;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent_count++;
  endtask

  // Init, get or delete with random content in the unused fields.
  task automatic send_cmd(input cmd_t cmd, input int sid);
    send_req(cmd, sid, $urandom_range(0, 255), $urandom_range(0, 127),
             1'($urandom_range(0, 1)));
  endtask

  // An insert run of nbytes bytes; noisy runs vary the length on later bytes.
  task automatic insert_run(input int tlen, input int nbytes, input bit close,
                            input bit noisy);
    for (int i = 0; i < nbytes; i++) begin
      send_req(CMD_INSERT, $urandom_range(0, 1023), $urandom_range(0, 255),
               (noisy && i > 0) ? $urandom_range(0, 127) : tlen,
               close && (i == nbytes - 1));
    end
  endtask

  // Stop sending until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // Mostly slots that can exist, now and then anywhere in the id range.
  function automatic int pick_slot();
    return ($urandom_range(0, 4) != 0) ? $urandom_range(0, 70) : $urandom_range(0, 1023);
  endfunction

  initial begin
    int kind;
    int tlen;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_INIT;
    in_ch.slot_id   = '0;
    in_ch.data_byte = '0;
    in_ch.tuple_len = '0;
    in_ch.last      = 1'b0;
    out_ch.ready    = 1'b0;
    idle_on         = 1'b1;
    sent_count      = 0;
    stall_left      = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty page, field extremes, every command and odd runs.
    send_cmd(CMD_INIT, 0);
    send_cmd(CMD_GET, 0);
    send_cmd(CMD_DELETE, 1023);
    send_req(CMD_INSERT, 0, 8'h00, 3, 1'b0);
    send_req(CMD_INSERT, 1023, 8'hff, 3, 1'b0);
    send_req(CMD_INSERT, 0, 8'ha5, 3, 1'b1);
    // Zero-length tuple, then two that are too long.
    send_req(CMD_INSERT, 0, 8'h5a, 0, 1'b1);
    send_req(CMD_INSERT, 0, 8'h80, 127, 1'b1);
    send_req(CMD_INSERT, 0, 8'h7f, 65, 1'b1);
    // Short run, long run, and a run cut off by a get.
    insert_run(MAX_TUPLE_LEN, 2, 1'b1, 1'b0);
    insert_run(2, 4, 1'b1, 1'b0);
    insert_run(5, 2, 1'b0, 1'b0);
    send_cmd(CMD_GET, 0);
    send_cmd(CMD_GET, 1);
    send_cmd(CMD_GET, 2);
    send_cmd(CMD_GET, 3);
    // Delete, read the hole, delete it again.
    send_cmd(CMD_DELETE, 1);
    send_cmd(CMD_GET, 1);
    send_cmd(CMD_DELETE, 1);

    // Fill the page with one-byte runs of long tuples until space runs out.
    send_cmd(CMD_INIT, 0);
    repeat (64) begin
      send_req(CMD_INSERT, $urandom_range(0, 1023), $urandom_range(0, 255),
               $urandom_range(60, MAX_TUPLE_LEN), 1'b1);
    end
    send_req(CMD_INSERT, 0, $urandom_range(0, 255), 0, 1'b1);
    repeat (4) send_cmd(CMD_GET, $urandom_range(0, 70));
    drain();

    // Random sequences: mostly well-formed inserts, gets and deletes.
    while (sent_count < ITEM_TARGET) begin
      idle_on = (sent_count < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        tlen = ($urandom_range(0, 7) == 0) ? $urandom_range(17, MAX_TUPLE_LEN)
                                          : $urandom_range(0, 16);
        insert_run(tlen, (tlen == 0) ? 1 : tlen, 1'b1, 1'b0);
      end else if (kind < 70) begin
        send_cmd(CMD_GET, pick_slot());
      end else if (kind < 80) begin
        send_cmd(CMD_DELETE, pick_slot());
      end else if (kind < 84) begin
        send_cmd(CMD_INIT, 0);
      end else if (kind < 88) begin
        insert_run($urandom_range(MAX_TUPLE_LEN + 1, 127), $urandom_range(1, 3), 1'b1, 1'b0);
      end else if (kind < 92) begin
        tlen = $urandom_range(2, MAX_TUPLE_LEN);
        insert_run(tlen, $urandom_range(1, tlen - 1), 1'b1, 1'b0);
      end else if (kind < 95) begin
        tlen = $urandom_range(0, 6);
        insert_run(tlen, tlen + $urandom_range(1, 4), 1'b1, 1'b0);
      end else if (kind < 98) begin
        tlen = $urandom_range(1, 16);
        insert_run(tlen, $urandom_range(1, tlen), 1'b0, 1'b0);
      end else begin
        tlen = $urandom_range(1, 12);
        insert_run(tlen, tlen, 1'b1, 1'b1);
      end
    end

    // Let the last results out, then watch for strays.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("slotted_page_store_unit regression: pass");
    end else begin
      $display("slotted_page_store_unit regression: fail");
    end
    $finish;
  end

endmodule
